// ===== rtl/tss_pkg.sv =====
// Shared constants and codes for the TDMA slot scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int MAX_SLOTS = 6;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 3;
    localparam int TIS_W     = 19;
    localparam int TTN_W     = 20;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [IDX_W-1:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLOT_LEN_0 = 3'd1;

endpackage

`default_nettype wire

// ===== rtl/tdma_slot_scheduler_unit.sv =====
// TDMA slot scheduler top level: config registers, sequencer and shared adder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  item     | item_valid/item_stall | op, now_ms
//  result   | res_valid/res_stall   | accepted, advanced, is_running, slot_now,
//           |                       | cycles_done, timing_valid, time_in_slot,
//           |                       | time_to_next
//  config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A request runs through these steps: accept, build the period and slot starts,
// the restoring divide, dispatch, the advance tests (one on a running tick, up
// to the number of slots in use on start, none on stop or while stopped), the
// final time fields when timing is valid, and post. With a zero period the
// divide is skipped.
// The single 20-bit add/subtract unit serves the prefix sums, the divide and the time fields.
// rst_n clears the config registers, the schedule state and the result valid.
// The item side stalls while a request is in work; a stalled result does not
// block the next request, only its posting.
`timescale 1ns / 1ps
`default_nettype none

module tdma_slot_scheduler_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic [1:0]                        op,
    input  wire logic [tss_pkg::TIME_W-1:0]        now_ms,
    // result channel
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic                                   accepted,
    output logic                                   advanced,
    output logic                                   is_running,
    output logic [tss_pkg::SLOT_W-1:0]             slot_now,
    output logic [tss_pkg::TIME_W-1:0]             cycles_done,
    output logic                                   timing_valid,
    output logic [tss_pkg::TIS_W-1:0]              time_in_slot,
    output logic signed [tss_pkg::TTN_W-1:0]       time_to_next,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tss_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [tss_pkg::LEN_W-1:0]         cfg_data
);

    localparam int AluW = tss_pkg::TTN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DISPATCH,
        ST_TIS,
        ST_FIX,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t                          state_reg;

    logic [tss_pkg::SLOT_W-1:0]      slot_count_reg;
    logic [tss_pkg::LEN_W-1:0]       slot_len_reg [tss_pkg::MAX_SLOTS];
    logic [tss_pkg::TIS_W-1:0]       start_reg    [tss_pkg::MAX_SLOTS];

    logic                            running_reg;
    logic [tss_pkg::SLOT_W-1:0]      slot_reg;
    logic [tss_pkg::TIME_W-1:0]      cur_cycle_reg;
    logic [tss_pkg::TIME_W-1:0]      cycle_count_reg;

    tss_pkg::op_t                    op_reg;
    logic [tss_pkg::CNT_W-1:0]       count_reg;
    logic [tss_pkg::SLOT_W-1:0]      left_reg;
    logic                            final_reg;
    logic                            acc_reg;
    logic                            adv_reg;
    logic [tss_pkg::TIS_W-1:0]       period_reg;
    logic [tss_pkg::TIME_W-1:0]      quo_reg;    // dividend in, cycle number out
    logic [tss_pkg::TIS_W-1:0]       rem_reg;    // position in cycle
    logic [AluW-1:0]                 diff_reg;
    logic [tss_pkg::TIS_W-1:0]       tis_reg;
    logic [tss_pkg::TTN_W-1:0]       ttn_reg;

    logic                            res_valid_reg;
    logic                            accepted_reg;
    logic                            advanced_reg;
    logic                            is_running_reg;
    logic [tss_pkg::SLOT_W-1:0]      slot_now_reg;
    logic [tss_pkg::TIME_W-1:0]      cycles_done_reg;
    logic                            timing_valid_reg;
    logic [tss_pkg::TIS_W-1:0]       time_in_slot_reg;
    logic [tss_pkg::TTN_W-1:0]       time_to_next_reg;

    logic [tss_pkg::SLOT_W-1:0]      n_used;
    logic [tss_pkg::SLOT_W-1:0]      slot_eff;
    logic [tss_pkg::SLOT_W-1:0]      slot_inc;
    logic [tss_pkg::SLOT_W-1:0]      len_idx;
    logic [tss_pkg::LEN_W-1:0]       len_rd;
    logic [tss_pkg::LEN_W-1:0]       len_sum;
    logic [AluW-1:0]                 trial;
    logic                            sched_ok;
    logic                            valid_now;
    logic                            item_take;
    logic                            post_ok;

    // shared add/subtract unit
    logic [AluW-1:0]                 alu_a;
    logic [AluW-1:0]                 alu_b;
    logic                            alu_sub;
    logic [AluW:0]                   alu_res;
    logic                            borrow;

    always_comb
    begin
        n_used = (slot_count_reg > tss_pkg::SLOT_W'(tss_pkg::MAX_SLOTS))
                 ? tss_pkg::SLOT_W'(tss_pkg::MAX_SLOTS) : slot_count_reg;
        slot_eff  = (slot_reg >= n_used) ? '0 : slot_reg;
        slot_inc  = slot_reg + 3'd1;
        len_idx   = (state_reg == ST_SUM) ? count_reg[tss_pkg::SLOT_W-1:0] : slot_eff;
        len_rd    = slot_len_reg[len_idx];
        len_sum   = (count_reg[tss_pkg::SLOT_W-1:0] < n_used) ? len_rd : '0;
        trial     = {rem_reg, quo_reg[tss_pkg::TIME_W-1]};
        sched_ok  = (n_used != '0) && (period_reg != '0);
        valid_now = running_reg && sched_ok;
        item_take = item_valid && (state_reg == ST_IDLE);
        post_ok   = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_SUM:
            begin
                alu_a = {1'b0, period_reg};
                alu_b = {4'b0, len_sum};
            end
            ST_DIV:
            begin
                alu_a   = trial;
                alu_b   = {1'b0, period_reg};
                alu_sub = 1'b1;
            end
            ST_TIS:
            begin
                alu_a   = {1'b0, rem_reg};
                alu_b   = {1'b0, start_reg[slot_eff]};
                alu_sub = 1'b1;
            end
            ST_FIX:
            begin
                alu_a = diff_reg;
                alu_b = {1'b0, period_reg};
            end
            ST_CMP:
            begin
                alu_a   = {4'b0, len_rd};
                alu_b   = {1'b0, tis_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                          : ({1'b0, alu_a} + {1'b0, alu_b});
        borrow  = alu_res[AluW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_count_reg   <= '0;
            for (int i = 0; i < tss_pkg::MAX_SLOTS; i++)
            begin
                slot_len_reg[i] <= '0;
                start_reg[i]    <= '0;
            end
            running_reg      <= 1'b0;
            slot_reg         <= '0;
            cur_cycle_reg    <= '0;
            cycle_count_reg  <= '0;
            op_reg           <= tss_pkg::OP_TICK;
            count_reg        <= '0;
            left_reg         <= '0;
            final_reg        <= 1'b0;
            acc_reg          <= 1'b0;
            adv_reg          <= 1'b0;
            period_reg       <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            diff_reg         <= '0;
            tis_reg          <= '0;
            ttn_reg          <= '0;
            res_valid_reg    <= 1'b0;
            accepted_reg     <= 1'b0;
            advanced_reg     <= 1'b0;
            is_running_reg   <= 1'b0;
            slot_now_reg     <= '0;
            cycles_done_reg  <= '0;
            timing_valid_reg <= 1'b0;
            time_in_slot_reg <= '0;
            time_to_next_reg <= '0;
        end
        else
        begin
            // a result posted in ST_DONE this cycle keeps the valid high
            if (res_valid_reg && !res_stall && state_reg != ST_DONE)
            begin
                res_valid_reg <= 1'b0;
            end

            // config is frozen while the schedule runs
            if (cfg_valid && cfg_ready && !running_reg)
            begin
                if (cfg_index == tss_pkg::REG_SLOT_COUNT)
                begin
                    slot_count_reg <= cfg_data[tss_pkg::SLOT_W-1:0];
                end
                else if (cfg_index >= tss_pkg::REG_SLOT_LEN_0 &&
                         cfg_index <= tss_pkg::IDX_W'(tss_pkg::MAX_SLOTS))
                begin
                    slot_len_reg[tss_pkg::SLOT_W'(cfg_index - tss_pkg::REG_SLOT_LEN_0)]
                        <= cfg_data;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        op_reg     <= tss_pkg::op_t'(op);
                        quo_reg    <= now_ms;
                        rem_reg    <= '0;
                        period_reg <= '0;
                        count_reg  <= '0;
                        acc_reg    <= 1'b0;
                        adv_reg    <= 1'b0;
                        final_reg  <= 1'b0;
                        state_reg  <= ST_SUM;
                    end
                end

                // prefix sums: start of each slot, then the period
                ST_SUM:
                begin
                    start_reg[count_reg[tss_pkg::SLOT_W-1:0]] <= period_reg;
                    period_reg <= alu_res[tss_pkg::TIS_W-1:0];
                    if (count_reg == tss_pkg::CNT_W'(tss_pkg::MAX_SLOTS - 1))
                    begin
                        count_reg <= '0;
                        state_reg <= (alu_res[tss_pkg::TIS_W-1:0] != '0)
                                     ? ST_DIV : ST_DISPATCH;
                    end
                    else
                    begin
                        count_reg <= count_reg + 5'd1;
                    end
                end

                // restoring divide, one quotient bit a cycle
                ST_DIV:
                begin
                    rem_reg <= borrow ? trial[tss_pkg::TIS_W-1:0]
                                      : alu_res[tss_pkg::TIS_W-1:0];
                    quo_reg <= {quo_reg[tss_pkg::TIME_W-2:0], !borrow};
                    if (count_reg == tss_pkg::CNT_W'(tss_pkg::TIME_W - 1))
                    begin
                        state_reg <= ST_DISPATCH;
                    end
                    count_reg <= count_reg + 5'd1;
                end

                ST_DISPATCH:
                begin
                    case (op_reg)
                        tss_pkg::OP_TICK:
                        begin
                            left_reg  <= 3'd1;
                            state_reg <= valid_now ? ST_TIS : ST_DONE;
                        end
                        tss_pkg::OP_START:
                        begin
                            if (sched_ok)
                            begin
                                running_reg   <= 1'b1;
                                slot_reg      <= '0;
                                cur_cycle_reg <= quo_reg;
                                acc_reg       <= 1'b1;
                                left_reg      <= n_used;
                                state_reg     <= ST_TIS;
                            end
                            else
                            begin
                                final_reg <= 1'b1;
                                state_reg <= valid_now ? ST_TIS : ST_DONE;
                            end
                        end
                        tss_pkg::OP_STOP:
                        begin
                            running_reg <= 1'b0;
                            slot_reg    <= '0;
                            acc_reg     <= 1'b1;
                            state_reg   <= ST_DONE;
                        end
                        default:
                        begin
                            final_reg <= 1'b1;
                            state_reg <= valid_now ? ST_TIS : ST_DONE;
                        end
                    endcase
                end

                // time in slot: pos - start, wrapped by one period if negative
                ST_TIS:
                begin
                    slot_reg <= slot_eff;
                    if (borrow)
                    begin
                        diff_reg  <= alu_res[AluW-1:0];
                        state_reg <= ST_FIX;
                    end
                    else
                    begin
                        tis_reg   <= alu_res[tss_pkg::TIS_W-1:0];
                        state_reg <= ST_CMP;
                    end
                end

                ST_FIX:
                begin
                    tis_reg   <= alu_res[tss_pkg::TIS_W-1:0];
                    state_reg <= ST_CMP;
                end

                // len - tis: borrow means the slot is overrun
                ST_CMP:
                begin
                    if (final_reg)
                    begin
                        ttn_reg   <= alu_res[AluW-1:0];
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        if (borrow)
                        begin
                            if (slot_inc >= n_used)
                            begin
                                cycle_count_reg <= cycle_count_reg + 32'd1;
                                cur_cycle_reg   <= quo_reg;
                                slot_reg        <= '0;
                            end
                            else
                            begin
                                slot_reg <= slot_inc;
                            end
                        end
                        else if (quo_reg != cur_cycle_reg)
                        begin
                            cycle_count_reg <= cycle_count_reg + 32'd1;
                            cur_cycle_reg   <= quo_reg;
                            slot_reg        <= '0;
                        end

                        if (op_reg == tss_pkg::OP_TICK)
                        begin
                            adv_reg <= borrow || (quo_reg != cur_cycle_reg);
                            acc_reg <= borrow || (quo_reg != cur_cycle_reg);
                        end

                        if ((borrow || (quo_reg != cur_cycle_reg)) && left_reg > 3'd1)
                        begin
                            left_reg <= left_reg - 3'd1;
                        end
                        else
                        begin
                            final_reg <= 1'b1;
                        end
                        state_reg <= ST_TIS;
                    end
                end

                ST_DONE:
                begin
                    if (post_ok)
                    begin
                        res_valid_reg    <= 1'b1;
                        accepted_reg     <= acc_reg;
                        advanced_reg     <= adv_reg;
                        is_running_reg   <= running_reg;
                        slot_now_reg     <= running_reg ? slot_reg : '0;
                        cycles_done_reg  <= cycle_count_reg;
                        timing_valid_reg <= valid_now;
                        time_in_slot_reg <= valid_now ? tis_reg : '0;
                        time_to_next_reg <= valid_now ? ttn_reg : '0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign res_valid    = res_valid_reg;
    assign accepted     = accepted_reg;
    assign advanced     = advanced_reg;
    assign is_running   = is_running_reg;
    assign slot_now     = slot_now_reg;
    assign cycles_done  = cycles_done_reg;
    assign timing_valid = timing_valid_reg;
    assign time_in_slot = time_in_slot_reg;
    assign time_to_next = time_to_next_reg;

endmodule

`default_nettype wire
